// File: sv/deulp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the DNS EDNS0 UDP payload limit parser.
// Phase codes, header offsets, limits and the parser state record. No dependencies.
package deulp_pkg;

  // Longest message accepted before it counts as malformed
  localparam int unsigned MAX_MSG_BYTES = 65535;

  // Parse phases
  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_NAME      = 3'd1;
  localparam logic [2:0] PH_LABEL     = 3'd2;
  localparam logic [2:0] PH_POINTER   = 3'd3;
  localparam logic [2:0] PH_FIXED     = 3'd4;
  localparam logic [2:0] PH_RDATA     = 3'd5;
  localparam logic [2:0] PH_DONE_NONE = 3'd6;
  localparam logic [2:0] PH_DONE_OPT  = 3'd7;

  // Offsets of the last byte of each header count
  localparam logic [15:0] HDR_QDCOUNT_END = 16'd5;
  localparam logic [15:0] HDR_ANCOUNT_END = 16'd7;
  localparam logic [15:0] HDR_NSCOUNT_END = 16'd9;
  localparam logic [15:0] HDR_ARCOUNT_END = 16'd11;
  localparam logic [15:0] HDR_BYTES       = 16'd12;

  localparam logic [15:0] TYPE_OPT      = 16'd41;
  localparam logic [15:0] MIN_LIMIT     = 16'd512;
  localparam logic [15:0] MAX_LIMIT     = 16'd65507;
  localparam logic [7:0]  MAX_LABEL_LEN = 8'd63;

  localparam logic [3:0] QFIXED_BYTES  = 4'd4;
  localparam logic [3:0] RR_TYPE_END   = 4'd2;
  localparam logic [3:0] RR_CLASS_END  = 4'd4;
  localparam logic [3:0] RR_FIXED_BYTES = 4'd10;

  typedef struct packed {
    logic [15:0] byte_offset;
    logic [2:0]  phase;
    logic [15:0] q_left;
    logic [16:0] other_cnt;
    logic [17:0] total_cnt;
    logic [17:0] rec_idx;
    logic [5:0]  label_left;
    logic [3:0]  fixed_cnt;
    logic [15:0] hshift;
    logic [15:0] rec_type;
    logic [15:0] pay_size;
    logic [15:0] rdata_left;
    logic [15:0] qend_pos;
    logic [15:0] limit;
    logic        outcome;
    logic        too_long;
  } parse_state_t;

  function automatic parse_state_t parse_reset();
    parse_state_t s;
    s            = '0;
    s.phase      = PH_HEADER;
    s.limit      = MIN_LIMIT;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: sv/deulp_step.sv
`timescale 1ns / 1ps
`default_nettype none
// One-byte update of the DNS message parser state, plus the result it implies.
// Depends on deulp_pkg.
module deulp_step import deulp_pkg::*; (
  input  wire parse_state_t st_i,
  input  wire logic [7:0]   data_i,
  output parse_state_t      st_o,
  output logic [15:0]       resp_size_o,
  output logic [15:0]       qsec_end_o,
  output logic              opt_found_o
);

  logic [15:0] hs;
  logic [15:0] idx;
  logic        in_rec;
  logic [5:0]  lbl_dec;
  logic [15:0] q_dec;
  logic [15:0] rd_dec;
  logic [3:0]  fix_inc;
  logic [17:0] hdr_total;

  assign hs        = {st_i.hshift[7:0], data_i};
  assign idx       = st_i.byte_offset;
  assign in_rec    = (st_i.qend_pos != 16'd0);
  assign lbl_dec   = st_i.label_left - 6'd1;
  assign q_dec     = st_i.q_left - 16'd1;
  assign rd_dec    = st_i.rdata_left - 16'd1;
  assign fix_inc   = st_i.fixed_cnt + 4'd1;
  assign hdr_total = {1'b0, st_i.other_cnt} + {2'b00, hs};

  function automatic parse_state_t finish(parse_state_t s, logic [2:0] ph, logic [15:0] lim);
    parse_state_t r;
    r         = s;
    r.phase   = ph;
    r.limit   = lim;
    r.outcome = 1'b1;
    return r;
  endfunction

  function automatic parse_state_t start_records(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.total_cnt == 18'd0) begin
      r = finish(s, PH_DONE_NONE, MIN_LIMIT);
    end else begin
      r.rec_idx = '0;
      r.phase   = PH_NAME;
    end
    return r;
  endfunction

  function automatic parse_state_t record_done(parse_state_t s);
    parse_state_t r;
    logic [15:0]  v;
    logic [17:0]  nidx;
    r    = s;
    v    = s.pay_size;
    nidx = s.rec_idx + 18'd1;
    if (v < MIN_LIMIT) v = MIN_LIMIT;
    if (v > MAX_LIMIT) v = MAX_LIMIT;
    if ((s.rec_idx >= {1'b0, s.other_cnt}) && (s.rec_type == TYPE_OPT)) begin
      r = finish(s, PH_DONE_OPT, v);
    end else begin
      r.rec_idx = nidx;
      if (nidx >= s.total_cnt) r = finish(r, PH_DONE_NONE, MIN_LIMIT);
      else                     r.phase = PH_NAME;
    end
    return r;
  endfunction

  always_comb begin
    st_o = st_i;
    if ({1'b0, st_i.byte_offset} >= 17'(MAX_MSG_BYTES)) begin
      st_o.too_long = 1'b1;
    end else begin
      st_o.byte_offset = st_i.byte_offset + 16'd1;
      if (!st_i.too_long && !st_i.outcome) begin
        st_o.hshift = hs;
        case (st_i.phase)
          PH_HEADER: begin
            if (idx == HDR_QDCOUNT_END) begin
              st_o.q_left = hs;
            end else if (idx == HDR_ANCOUNT_END) begin
              st_o.other_cnt = {1'b0, hs};
            end else if (idx == HDR_NSCOUNT_END) begin
              st_o.other_cnt = st_i.other_cnt + {1'b0, hs};
            end else if (idx == HDR_ARCOUNT_END) begin
              st_o.total_cnt = hdr_total;
              if (st_i.q_left == 16'd0) begin
                st_o.qend_pos = HDR_BYTES;
                st_o = start_records(st_o);
              end else begin
                st_o.phase = PH_NAME;
              end
            end
          end
          PH_NAME: begin
            if (data_i == 8'd0) begin
              st_o.fixed_cnt = '0;
              st_o.phase     = PH_FIXED;
            end else if (data_i[7:6] == 2'b11) begin
              st_o.phase = PH_POINTER;
            end else if (data_i > MAX_LABEL_LEN) begin
              st_o = finish(st_o, PH_DONE_NONE, MIN_LIMIT);
            end else begin
              st_o.label_left = data_i[5:0];
              st_o.phase      = PH_LABEL;
            end
          end
          PH_LABEL: begin
            st_o.label_left = lbl_dec;
            if (lbl_dec == 6'd0) st_o.phase = PH_NAME;
          end
          PH_POINTER: begin
            st_o.fixed_cnt = '0;
            st_o.phase     = PH_FIXED;
          end
          PH_FIXED: begin
            st_o.fixed_cnt = fix_inc;
            if (!in_rec) begin
              if (fix_inc == QFIXED_BYTES) begin
                st_o.q_left = q_dec;
                if (q_dec == 16'd0) begin
                  st_o.qend_pos = idx + 16'd1;
                  st_o = start_records(st_o);
                end else begin
                  st_o.phase = PH_NAME;
                end
              end
            end else begin
              if (fix_inc == RR_TYPE_END) begin
                st_o.rec_type = hs;
              end else if (fix_inc == RR_CLASS_END) begin
                st_o.pay_size = hs;
              end else if (fix_inc == RR_FIXED_BYTES) begin
                st_o.rdata_left = hs;
                if (hs == 16'd0) st_o = record_done(st_o);
                else             st_o.phase = PH_RDATA;
              end
            end
          end
          PH_RDATA: begin
            st_o.rdata_left = rd_dec;
            if (rd_dec == 16'd0) st_o = record_done(st_o);
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (st_o.too_long) begin
      resp_size_o = MIN_LIMIT;
      qsec_end_o  = '0;
      opt_found_o = 1'b0;
    end else if (st_o.phase == PH_DONE_OPT) begin
      resp_size_o = st_o.limit;
      qsec_end_o  = st_o.qend_pos;
      opt_found_o = 1'b1;
    end else begin
      resp_size_o = MIN_LIMIT;
      qsec_end_o  = st_o.qend_pos;
      opt_found_o = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/dns_edns_udp_limit_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the DNS EDNS0 UDP payload limit parser.
// Depends on deulp_pkg and deulp_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per transaction,
//   in wire order; in_last_byte marks the final byte of a message.
//   Result channel (out_valid/out_ready) carries one transaction per message:
//   the UDP size limit (512 unless an additional-section OPT record gave one,
//   clamped to 512..65507), the offset just past the question section (0 if
//   the header or questions are malformed or cut short) and an OPT flag.
// Timing:
//   Bytes are taken one per cycle while the input is not stalled (see Stalls).
//   Each byte sits in an input register, then one pass of the byte-update
//   logic folds it into the parser state. With the result slot free, the
//   result of a message is registered in the result register once its last
//   byte leaves the input register, and out_valid rises with it.
// Stalls:
//   The result register holds one finished result. If it is still full when
//   the next message's last byte reaches the parser, that byte waits in the
//   input register and in_ready drops until out_ready frees the slot; other
//   bytes keep flowing while a result waits.
// Reset:
//   rst_n (synchronous, active low) empties both registers and returns the
//   parser to the header phase. The parser also clears itself after each
//   message's last byte.
module dns_edns_udp_limit_parser_top import deulp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_resp_size,
  output logic [15:0]      out_qsec_end,
  output logic             out_opt_found
);

  // input stage
  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_data_r;
  logic        in_last_r;

  // parser state
  parse_state_t st_r;
  parse_state_t st_nxt;

  // result stage
  logic        out_vld_r, out_vld_nxt;
  logic [15:0] resp_size_r, resp_size_nxt;
  logic [15:0] qend_r, qend_nxt;
  logic        opt_found_r, opt_found_nxt;

  logic consume;
  logic in_take;

  // A non-final byte always moves on; the final one needs a free result slot.
  assign consume  = in_vld_r && (!in_last_r || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || consume;
  assign in_take  = in_valid && in_ready;

  assign in_vld_nxt  = in_take ? 1'b1 : (consume ? 1'b0 : in_vld_r);
  assign out_vld_nxt = (consume && in_last_r) ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  deulp_step u_step (
    .st_i        (st_r),
    .data_i      (in_data_r),
    .st_o        (st_nxt),
    .resp_size_o (resp_size_nxt),
    .qsec_end_o  (qend_nxt),
    .opt_found_o (opt_found_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= parse_reset();
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (consume) begin
        st_r <= in_last_r ? parse_reset() : st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
    if (consume && in_last_r) begin
      resp_size_r <= resp_size_nxt;
      qend_r      <= qend_nxt;
      opt_found_r <= opt_found_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_resp_size = resp_size_r;
  assign out_qsec_end  = qend_r;
  assign out_opt_found = opt_found_r;

`ifndef NO_ASSERTIONS
  a_limit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (resp_size_r >= MIN_LIMIT) && (resp_size_r <= MAX_LIMIT))
    else $error("udp limit out of range");

  a_default_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !opt_found_r) |-> (resp_size_r == MIN_LIMIT))
    else $error("limit set without OPT record");

  a_opt_after_questions : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && opt_found_r) |-> (qend_r != 16'd0))
    else $error("OPT reported without complete questions");

  a_state_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_last_r) |=> (st_r.byte_offset == 16'd0) && (st_r.phase == PH_HEADER))
    else $error("parser not cleared after message end");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && in_last_r && out_vld_r && !out_ready))
    else $error("input stalled without a full result slot");
`endif

endmodule

`default_nettype wire
